### design/assert_macros.svh
// Assertion helper macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: label");

// when ante holds, cons must hold at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

### design/hil_pkg.sv
// Types, character constants and hex decode for the hex image loader
package hil_pkg;

  localparam logic [7:0]  CHAR_NUL   = 8'h00;
  localparam logic [7:0]  CHAR_TAB   = 8'h09;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  CHAR_AT    = 8'h40;
  localparam logic [31:0] START_RESET = 32'd65536;  // 64 KiB

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_ECHO  = 2'd1,
    KIND_BLOCK = 2'd2,
    KIND_RUN   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [31:0] byte_count;
    logic [7:0]  echo_first;
    logic [7:0]  echo_second;
    logic        echo_two;
    logic        last;
  } result_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### design/hex_image_loader_parser.sv
// Hex image loader: parses console characters into byte writes and reports
//
// Input stream (s_*): one ASCII character per word in s_tdata[7:0].
// Output stream (m_*): one result per word; m_tuser holds the kind
// (byte write, error echo, block report, run), m_tlast marks the final
// result caused by one character. A character yields zero, one or two results.
// APB port: register 0 (byte address 0) is the start address; writing it
// also reloads the current load base. Reads return the start address.
// An accepted character is held in an input register; the parser stage
// then consumes it, updates all state and hands its results to a four-word
// output queue. Throughput: one character per cycle while the queue has room.
// The parser stage stalls only when the queue has fewer than two free
// words, which happens only when the receiver holds m_tready low.
// Reset clears the parser to idle, empties the queue, and restores the
// start address and load base to 64 KiB. After a NUL the run result is
// issued and every later character is taken and dropped until reset.
module hex_image_loader_parser
  import hil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] address, [39:32] data_byte,
                                 // [71:40] byte_count, [79:72] echo_first,
                                 // [87:80] echo_second, [88] echo_two, rest 0
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ADDR,
    MODE_HEX,
    MODE_HALT
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  pending_char, pending_char_next;
  logic [31:0] start_address;
  logic [31:0] base_address, base_address_next;
  logic [31:0] written_count, written_count_next;
  logic [31:0] addr_acc, addr_acc_next;

  logic        in_valid, in_valid_next;
  logic [7:0]  in_char;

  result_t     queue [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count, count_next;

  logic        consume, in_take, out_take, cfg_write;
  logic [1:0]  push_n;
  result_t     res0, res1;
  logic [4:0]  hex_in, hex_pend;
  result_t     head_res;

  assign pready    = 1'b1;
  assign prdata    = start_address;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

  assign consume  = in_valid && (count <= CNT_W'(DEPTH - 2));
  assign s_tready = !in_valid || consume;
  assign in_take  = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  assign hex_in   = hex_decode(in_char);
  assign hex_pend = hex_decode(pending_char);

  always_comb begin
    mode_next          = mode;
    pending_char_next  = pending_char;
    base_address_next  = base_address;
    written_count_next = written_count;
    addr_acc_next      = addr_acc;
    push_n             = 2'd0;
    res0               = '0;
    res1               = '0;
    res0.last          = 1'b1;
    res1.last          = 1'b1;
    if (consume) begin
      unique case (mode)
        MODE_ADDR: begin
          if (hex_in[4]) begin
            addr_acc_next = {addr_acc[27:0], hex_in[3:0]};
          end else begin
            base_address_next  = addr_acc;
            written_count_next = '0;
            mode_next          = MODE_IDLE;
          end
        end
        MODE_HEX: begin
          push_n = 2'd1;
          if (hex_in[4]) begin
            res0.kind          = KIND_WRITE;
            res0.address       = base_address + written_count;
            res0.data_byte     = {hex_pend[3:0], hex_in[3:0]};
            written_count_next = written_count + 32'd1;
          end else begin
            res0.kind        = KIND_ECHO;
            res0.echo_first  = pending_char;
            res0.echo_second = in_char;
            res0.echo_two    = 1'b1;
          end
          mode_next = MODE_IDLE;
        end
        MODE_IDLE: begin
          if (in_char == CHAR_NUL || in_char == CHAR_AT) begin
            // block report first when the block holds data
            res0.kind       = KIND_BLOCK;
            res0.address    = base_address;
            res0.byte_count = written_count;
            res0.last       = (in_char != CHAR_NUL);
            res1.kind       = KIND_RUN;
            if (in_char == CHAR_NUL) begin
              mode_next = MODE_HALT;
              if (written_count != '0) begin
                push_n = 2'd2;
              end else begin
                push_n = 2'd1;
                res0   = res1;
              end
            end else begin
              push_n        = (written_count != '0) ? 2'd1 : 2'd0;
              addr_acc_next = '0;
              mode_next     = MODE_ADDR;
            end
          end else if (hex_in[4]) begin
            pending_char_next = in_char;
            mode_next         = MODE_HEX;
          end else if (in_char == CHAR_SPACE || in_char == CHAR_TAB ||
                       in_char == CHAR_CR || in_char == CHAR_LF) begin
            push_n = 2'd0;
          end else begin
            push_n          = 2'd1;
            res0.kind       = KIND_ECHO;
            res0.echo_first = in_char;
          end
        end
        MODE_HALT: begin
          push_n = 2'd0;
        end
        default: begin
          push_n = 2'd0;
        end
      endcase
    end
    if (cfg_write) begin
      base_address_next = pwdata;
    end
  end

  always_comb begin
    in_valid_next = in_valid;
    if (in_take) begin
      in_valid_next = 1'b1;
    end else if (consume) begin
      in_valid_next = 1'b0;
    end
    count_next = count + CNT_W'(push_n) - CNT_W'(out_take);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      pending_char  <= '0;
      start_address <= START_RESET;
      base_address  <= START_RESET;
      written_count <= '0;
      addr_acc      <= '0;
      in_valid      <= 1'b0;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
    end else begin
      mode          <= mode_next;
      pending_char  <= pending_char_next;
      base_address  <= base_address_next;
      written_count <= written_count_next;
      addr_acc      <= addr_acc_next;
      in_valid      <= in_valid_next;
      count         <= count_next;
      tail          <= tail + PTR_W'(push_n);
      if (out_take) begin
        head <= head + PTR_W'(1);
      end
      if (cfg_write) begin
        start_address <= pwdata;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char <= s_tdata;
    end
    if (push_n != 2'd0) begin
      queue[tail] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[tail + PTR_W'(1)] <= res1;
    end
  end

  assign head_res = queue[head];
  assign m_tvalid = (count != '0);
  assign m_tuser  = head_res.kind;
  assign m_tlast  = head_res.last;
  assign m_tdata  = {7'd0, head_res.echo_two, head_res.echo_second, head_res.echo_first,
                     head_res.byte_count, head_res.data_byte, head_res.address};

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_queue_bound, clk, rst, count <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_halt_sticks, clk, rst, mode == MODE_HALT, mode == MODE_HALT && push_n == 2'd0)
  `ASSERT_NEXT(a_stall_holds, clk, rst, in_valid && !consume, in_valid && $stable(in_char))
  `ASSERT_NEXT(a_no_push_full, clk, rst, count == CNT_W'(DEPTH), push_n == 2'd0 || out_take)

endmodule
